FILE: src/ppcs_pkg.sv
// Shared constants for the path point cascade smoother.
// Used by the top level and by the constant floor divider; depends on nothing.
`default_nettype none

package ppcs_pkg;

    // Default coordinate width (signed Q16.16 at the default).
    localparam int COORD_WIDTH_DEF = 32;

    // Guard bits that make a sum of up to five coordinates exact.
    localparam int SUM_GUARD = 3;

    // Divisors of the two smoothing passes.
    localparam int DIV_FIRST  = 3;
    localparam int DIV_SECOND = 5;

    // Cycles from divider input register to quotient.
    localparam int DIV_LATENCY = 3;

    // Result groups held between the datapath and the output port.
    localparam int GRP_DEPTH = 16;

    // Result slots of one group, in the order they leave the block.
    localparam int NUM_SLOTS = 4;
    localparam logic [1:0] SLOT_RA = 2'd0;  // five-point mean, or pass-through
    localparam logic [1:0] SLOT_RB = 2'd1;  // second-to-last five-point mean
    localparam logic [1:0] SLOT_Q  = 2'd2;  // last first-pass value
    localparam logic [1:0] SLOT_P  = 2'd3;  // the final raw point

    // Saturation value of the per-path point counter.
    localparam logic [2:0] SEEN_MAX = 3'd7;

endpackage

`default_nettype wire

FILE: src/ppcs_floor_div.sv
// Pipelined floor division of a signed sum by a small constant divisor.
// Uses ppcs_pkg for the default width, the default divisor and the sum guard bits.
`default_nettype none

module ppcs_floor_div #(
    parameter  int COORD_WIDTH = ppcs_pkg::COORD_WIDTH_DEF,
    parameter  int DIVISOR     = ppcs_pkg::DIV_FIRST,
    localparam int SW          = COORD_WIDTH + ppcs_pkg::SUM_GUARD
) (
    input  wire logic                          aclk,
    input  wire logic signed [SW-1:0]          sum_in,
    output logic signed [COORD_WIDTH-1:0]      quot_out
);

    // The sum is biased to a non-negative value so that floor division
    // becomes an unsigned reciprocal multiply; the bias divides out exactly
    // to 2^(COORD_WIDTH-1), which is removed by flipping the quotient MSB.
    localparam int K    = SW + 3;
    localparam int MW   = K - 1;
    localparam int LO_W = SW / 2;
    localparam int HI_W = SW - LO_W;
    localparam int FW   = SW + MW;

    localparam logic [K:0]    TWO_K  = {1'b1, {K{1'b0}}};
    localparam logic [K:0]    M_FULL = (TWO_K + (K+1)'(DIVISOR - 1)) / (K+1)'(DIVISOR);
    localparam logic [MW-1:0] MULT   = M_FULL[MW-1:0];
    localparam logic [SW-1:0] OFFSET = SW'(DIVISOR) << (COORD_WIDTH - 1);

    logic [SW-1:0]        u_reg;
    logic [LO_W+MW-1:0]   plo_reg;
    logic [HI_W+MW-1:0]   phi_reg;
    logic [COORD_WIDTH-1:0] quot_reg;
    logic [FW-1:0]        full_prod;

    assign full_prod = (FW'(phi_reg) << LO_W) + FW'(plo_reg);

    always_ff @(posedge aclk) begin
        u_reg    <= $unsigned(sum_in) + OFFSET;
        plo_reg  <= (LO_W+MW)'(u_reg[LO_W-1:0]) * (LO_W+MW)'(MULT);
        phi_reg  <= (HI_W+MW)'(u_reg[SW-1:LO_W]) * (HI_W+MW)'(MULT);
        quot_reg <= {~full_prod[K+COORD_WIDTH-1], full_prod[K+COORD_WIDTH-2:K]};
    end

    assign quot_out = $signed(quot_reg);

endmodule

`default_nettype wire

FILE: src/path_point_cascade_smoother.sv
// Top level of the path point cascade smoother: a 3-point then 5-point mean.
// Depends on ppcs_pkg and instantiates ppcs_floor_div.
`default_nettype none

// Channel   Dir  Beat contents (low bits first)                  Marker
// s_        in   point_x, point_y, zero pad to whole bytes        s_tlast = is_last
// m_        out  smooth_x, smooth_y, zero pad to whole bytes      m_tlast = path_end
//
// One point is taken per cycle while fewer than sixteen points are in flight. A point
// produces a group of zero to four results. A group enters the output buffer once its point
// has passed both divider passes, and the buffer sends one result per cycle while m_tready
// is high. The three-stage reciprocal dividers set the latency.
// Reset (aresetn low at a clock edge) empties the pipeline and the buffer and
// starts a new path. A stall on m_ stops s_ only once sixteen points are in flight.

module path_point_cascade_smoother #(
    parameter  int COORD_WIDTH = ppcs_pkg::COORD_WIDTH_DEF,
    localparam int DATA_W      = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // point_x, point_y, zero pad
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata,   // smooth_x, smooth_y, zero pad
    output logic                   m_tlast
);

    localparam int W   = COORD_WIDTH;
    localparam int SW  = W + ppcs_pkg::SUM_GUARD;
    localparam int LAT = ppcs_pkg::DIV_LATENCY;
    localparam int GD  = ppcs_pkg::GRP_DEPTH;
    localparam int NS  = ppcs_pkg::NUM_SLOTS;
    localparam int PW  = $clog2(GD);
    localparam int CW  = $clog2(GD + 1);

    typedef logic signed [W-1:0]  coord_t;
    typedef logic signed [SW-1:0] acc_t;
    typedef struct packed { coord_t x; coord_t y; } point_t;
    typedef struct packed { acc_t x; acc_t y; } accp_t;

    // What travels beside the first-pass divider.
    typedef struct packed {
        logic [2:0] seen;
        logic       last;
        point_t     p;
        point_t     rw0;
        point_t     rw1;
    } side_a_t;

    // What travels beside the second-pass dividers.
    typedef struct packed {
        logic [NS-1:0]        mask;
        logic                 div0;
        logic                 div1;
        point_t [NS-1:0]      v;
    } side_b_t;

    // One buffered group of results; only the slots set in mask are sent.
    typedef struct packed {
        logic [NS-1:0]   mask;
        point_t [NS-1:0] slot;
    } group_t;

    // ------------------------------------------------------------------
    // Input stage: raw window, point counter and the three-point sum.
    // ------------------------------------------------------------------
    logic       accept_in;
    point_t     in_p;
    logic [2:0] seen_reg;
    point_t     rw0_reg;
    point_t     rw1_reg;
    logic       a_valid_reg;
    side_a_t    a_side_reg;
    accp_t      a_sum_reg;

    assign accept_in = s_tvalid && s_tready;
    assign in_p.x    = s_tdata[W-1:0];
    assign in_p.y    = s_tdata[2*W-1:W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= accept_in;
            if (accept_in) begin
                if (s_tlast) begin
                    seen_reg <= '0;
                end else if (seen_reg != ppcs_pkg::SEEN_MAX) begin
                    seen_reg <= seen_reg + 3'd1;
                end
            end
        end
    end

    // The raw window needs no reset: the point counter guards every read.
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            rw1_reg         <= rw0_reg;
            rw0_reg         <= in_p;
            a_side_reg.seen <= seen_reg;
            a_side_reg.last <= s_tlast;
            a_side_reg.p    <= in_p;
            a_side_reg.rw0  <= rw0_reg;
            a_side_reg.rw1  <= rw1_reg;
            a_sum_reg.x     <= acc_t'(rw1_reg.x) + acc_t'(rw0_reg.x) + acc_t'(in_p.x);
            a_sum_reg.y     <= acc_t'(rw1_reg.y) + acc_t'(rw0_reg.y) + acc_t'(in_p.y);
        end
    end

    // ------------------------------------------------------------------
    // First pass: divide by three, with the side data delayed alongside.
    // ------------------------------------------------------------------
    point_t  q3;
    side_a_t side_a_pipe [LAT];
    logic    [LAT-1:0] a_vpipe_reg;

    ppcs_floor_div #(.COORD_WIDTH(W), .DIVISOR(ppcs_pkg::DIV_FIRST)) u_div3_x (
        .aclk(aclk), .sum_in(a_sum_reg.x), .quot_out(q3.x)
    );
    ppcs_floor_div #(.COORD_WIDTH(W), .DIVISOR(ppcs_pkg::DIV_FIRST)) u_div3_y (
        .aclk(aclk), .sum_in(a_sum_reg.y), .quot_out(q3.y)
    );

    always_ff @(posedge aclk) begin
        side_a_pipe[0] <= a_side_reg;
        for (int i = 1; i < LAT; i++) begin
            side_a_pipe[i] <= side_a_pipe[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vpipe_reg <= '0;
        end else begin
            a_vpipe_reg <= {a_vpipe_reg[LAT-2:0], a_valid_reg};
        end
    end

    // ------------------------------------------------------------------
    // Second pass: first-pass window, five-point sums and slot selection.
    // The window sits here so it is updated in stream order with qn.
    // ------------------------------------------------------------------
    side_a_t bs;
    logic    b_in_valid;
    logic    short_last;
    point_t  qn;
    point_t  qw_reg [4];
    accp_t   b_sum0_next, b_sum1_next;
    side_b_t b_side_next;
    logic    b_valid_reg;
    accp_t   b_sum0_reg, b_sum1_reg;
    side_b_t b_side_reg;

    assign bs         = side_a_pipe[LAT-1];
    assign b_in_valid = a_vpipe_reg[LAT-1];
    // A path that ends within its first three points passes through raw.
    assign short_last = bs.last && (bs.seen < 3'd3);

    always_comb begin
        // The second point's first-pass value is the first point itself.
        qn.x = (bs.seen == 3'd1) ? bs.rw0.x : q3.x;
        qn.y = (bs.seen == 3'd1) ? bs.rw0.y : q3.y;

        b_sum0_next.x = acc_t'(qw_reg[3].x) + acc_t'(qw_reg[2].x) + acc_t'(qw_reg[1].x)
                      + acc_t'(qw_reg[0].x) + acc_t'(qn.x);
        b_sum0_next.y = acc_t'(qw_reg[3].y) + acc_t'(qw_reg[2].y) + acc_t'(qw_reg[1].y)
                      + acc_t'(qw_reg[0].y) + acc_t'(qn.y);
        b_sum1_next.x = acc_t'(qw_reg[2].x) + acc_t'(qw_reg[1].x) + acc_t'(qw_reg[0].x)
                      + acc_t'(qn.x) + acc_t'(bs.p.x);
        b_sum1_next.y = acc_t'(qw_reg[2].y) + acc_t'(qw_reg[1].y) + acc_t'(qw_reg[0].y)
                      + acc_t'(qn.y) + acc_t'(bs.p.y);

        b_side_next.div0 = (bs.seen >= 3'd5);
        b_side_next.div1 = (bs.seen >= 3'd4);
        b_side_next.v[ppcs_pkg::SLOT_RA] = qw_reg[1];
        b_side_next.v[ppcs_pkg::SLOT_RB] = short_last ? bs.rw1 : qw_reg[0];
        b_side_next.v[ppcs_pkg::SLOT_Q]  = short_last ? bs.rw0 : qn;
        b_side_next.v[ppcs_pkg::SLOT_P]  = bs.p;

        b_side_next.mask = '0;
        if (!bs.last) begin
            b_side_next.mask[ppcs_pkg::SLOT_RA] = (bs.seen >= 3'd3);
        end else if (short_last) begin
            b_side_next.mask[ppcs_pkg::SLOT_RB] = (bs.seen == 3'd2);
            b_side_next.mask[ppcs_pkg::SLOT_Q]  = (bs.seen != 3'd0);
            b_side_next.mask[ppcs_pkg::SLOT_P]  = 1'b1;
        end else begin
            b_side_next.mask = '1;
        end
    end

    // The window is read only where the counter shows it was filled.
    always_ff @(posedge aclk) begin
        if (b_in_valid && !bs.last && (bs.seen != 3'd0)) begin
            qw_reg[3] <= qw_reg[2];
            qw_reg[2] <= qw_reg[1];
            qw_reg[1] <= qw_reg[0];
            qw_reg[0] <= qn;
        end
        b_sum0_reg <= b_sum0_next;
        b_sum1_reg <= b_sum1_next;
        b_side_reg <= b_side_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_in_valid;
        end
    end

    // ------------------------------------------------------------------
    // Divide by five for the two mean slots.
    // ------------------------------------------------------------------
    point_t  r0, r1;
    side_b_t side_b_pipe [LAT];
    logic    [LAT-1:0] b_vpipe_reg;

    ppcs_floor_div #(.COORD_WIDTH(W), .DIVISOR(ppcs_pkg::DIV_SECOND)) u_div5_ax (
        .aclk(aclk), .sum_in(b_sum0_reg.x), .quot_out(r0.x)
    );
    ppcs_floor_div #(.COORD_WIDTH(W), .DIVISOR(ppcs_pkg::DIV_SECOND)) u_div5_ay (
        .aclk(aclk), .sum_in(b_sum0_reg.y), .quot_out(r0.y)
    );
    ppcs_floor_div #(.COORD_WIDTH(W), .DIVISOR(ppcs_pkg::DIV_SECOND)) u_div5_bx (
        .aclk(aclk), .sum_in(b_sum1_reg.x), .quot_out(r1.x)
    );
    ppcs_floor_div #(.COORD_WIDTH(W), .DIVISOR(ppcs_pkg::DIV_SECOND)) u_div5_by (
        .aclk(aclk), .sum_in(b_sum1_reg.y), .quot_out(r1.y)
    );

    always_ff @(posedge aclk) begin
        side_b_pipe[0] <= b_side_reg;
        for (int i = 1; i < LAT; i++) begin
            side_b_pipe[i] <= side_b_pipe[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vpipe_reg <= '0;
        end else begin
            b_vpipe_reg <= {b_vpipe_reg[LAT-2:0], b_valid_reg};
        end
    end

    // ------------------------------------------------------------------
    // Group assembly and the group buffer.
    // ------------------------------------------------------------------
    side_b_t cs;
    logic    c_valid;
    group_t  grp_in;
    logic    grp_push;
    logic    grp_drop;

    assign cs      = side_b_pipe[LAT-1];
    assign c_valid = b_vpipe_reg[LAT-1];

    always_comb begin
        grp_in.mask = cs.mask;
        grp_in.slot = cs.v;
        if (cs.div0) begin
            grp_in.slot[ppcs_pkg::SLOT_RA] = r0;
        end
        if (cs.div1) begin
            grp_in.slot[ppcs_pkg::SLOT_RB] = r1;
        end
    end

    // Points that produce no result still held a credit; release it here.
    assign grp_push = c_valid && (cs.mask != '0);
    assign grp_drop = c_valid && (cs.mask == '0);

    group_t        grp_mem [GD];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW-1:0] rd_next;
    logic [CW-1:0] grp_count_reg;
    logic [CW-1:0] reserved_reg;
    logic [NS-1:0] taken_reg;
    group_t        head_reg;
    logic [NS-1:0] rem;
    logic [1:0]    cur_idx;
    logic [NS-1:0] cur_oh;
    logic          out_fire;
    logic          last_of_grp;
    logic          pop;

    // The head group is read through a register at the address the read
    // pointer takes next. A group written to that same address in this cycle
    // is forwarded, which only happens when the buffer is about to be empty.
    assign rd_next = pop ? (rd_ptr_reg + PW'(1)) : rd_ptr_reg;

    always_ff @(posedge aclk) begin
        if (grp_push) begin
            grp_mem[wr_ptr_reg] <= grp_in;
        end
        if (grp_push && (wr_ptr_reg == rd_next)) begin
            head_reg <= grp_in;
        end else begin
            head_reg <= grp_mem[rd_next];
        end
    end

    assign rem = head_reg.mask & ~taken_reg;

    // Lowest slot still to be sent in the head group.
    always_comb begin
        cur_idx = ppcs_pkg::SLOT_P;
        for (int i = NS - 1; i >= 0; i--) begin
            if (rem[i]) begin
                cur_idx = 2'(i);
            end
        end
        cur_oh          = '0;
        cur_oh[cur_idx] = 1'b1;
    end

    assign m_tvalid    = (grp_count_reg != '0);
    assign m_tdata     = DATA_W'({head_reg.slot[cur_idx].y, head_reg.slot[cur_idx].x});
    // The final raw point only ever fills the last slot of a path-end group.
    assign m_tlast     = (cur_idx == ppcs_pkg::SLOT_P);
    assign out_fire    = m_tvalid && m_tready;
    assign last_of_grp = ((rem & ~cur_oh) == '0);
    assign pop         = out_fire && last_of_grp;

    // Every accepted point holds one credit until its group leaves or it proves to produce no
    // result, so the buffer can never overflow however long m_ stalls.
    assign s_tready = (reserved_reg < CW'(GD));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            grp_count_reg <= '0;
            reserved_reg  <= '0;
            taken_reg     <= '0;
        end else begin
            if (grp_push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            rd_ptr_reg    <= rd_next;
            grp_count_reg <= grp_count_reg + CW'(grp_push) - CW'(pop);
            reserved_reg  <= reserved_reg + CW'(accept_in) - CW'(pop) - CW'(grp_drop);
            if (pop) begin
                taken_reg <= '0;
            end else if (out_fire) begin
                taken_reg <= taken_reg | cur_oh;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_credit_covers_buffer: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_count_reg <= reserved_reg)
        else $error("group buffer holds more groups than were credited");

    a_head_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (rem != '0))
        else $error("head group offered with no result left to send");

    a_end_pops_group: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && m_tlast) |-> last_of_grp)
        else $error("path end sent before the rest of its group");

    a_last_restarts_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept_in && s_tlast) |=> (seen_reg == 3'd0))
        else $error("point counter not cleared after a path end");

endmodule

`default_nettype wire
